// ===== src/pss_pkg.sv =====
`default_nettype none
package pss_pkg;

	localparam int PAGE_DEPTH_DEF = 16;
	localparam int PAGE_COUNT_DEF = 8;

	localparam int ACTION_W    = 2;
	localparam int VALUE_W     = 32;
	localparam int INDEX_W     = 3;
	localparam int STATUS_W    = 2;
	localparam int AT_SIZE_W   = 5;
	localparam int TOTAL_W     = 8;
	localparam int PAGES_W     = 4;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH   = 2'd0,
		ACT_POP    = 2'd1,
		ACT_POP_AT = 2'd2,
		ACT_QUERY  = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2,
		STATUS_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_DONE = 2'd2
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} cmd_t;

endpackage
`default_nettype wire

// ===== src/pss_if.sv =====
`default_nettype none
interface pss_req_if;
	logic                              valid;
	logic                              ready;
	logic [pss_pkg::ACTION_W-1:0]      action;
	logic signed [pss_pkg::VALUE_W-1:0] value;
	logic [pss_pkg::INDEX_W-1:0]       stack_index;

	modport source(output valid, action, value, stack_index, input ready);
	modport sink(input valid, action, value, stack_index, output ready);
endinterface

interface pss_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [pss_pkg::STATUS_W-1:0]       status;
	logic signed [pss_pkg::VALUE_W-1:0] top_value;
	logic                               top_valid;
	logic signed [pss_pkg::VALUE_W-1:0] at_value;
	logic [pss_pkg::AT_SIZE_W-1:0]      at_size;
	logic                               at_valid;
	logic [pss_pkg::TOTAL_W-1:0]        total_count;
	logic [pss_pkg::PAGES_W-1:0]        page_count;
	logic                               is_empty;

	modport source(output valid, status, top_value, top_valid, at_value, at_size, at_valid,
		total_count, page_count, is_empty, input ready);
	modport sink(input valid, status, top_value, top_valid, at_value, at_size, at_valid,
		total_count, page_count, is_empty, output ready);
endinterface
`default_nettype wire

// ===== src/pss_ctrl.sv =====
`default_nettype none
module pss_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output pss_pkg::cmd_t       cmd
);

	pss_pkg::ctrl_state_t state_q, state_d;
	logic                 out_valid_q;
	logic                 slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pss_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		case (state_q)
			pss_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = pss_pkg::ST_EXEC;
				end
			end
			pss_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = pss_pkg::ST_DONE;
			end
			pss_pkg::ST_DONE: begin
				if (slot_free) begin
					cmd.load = 1'b1;
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.capture = 1'b1;
						state_d     = pss_pkg::ST_EXEC;
					end else begin
						state_d = pss_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = pss_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/pss_datapath.sv =====
`default_nettype none
module pss_datapath #(
	parameter int PAGE_DEPTH = pss_pkg::PAGE_DEPTH_DEF,
	parameter int PAGE_COUNT = pss_pkg::PAGE_COUNT_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire pss_pkg::cmd_t                      cmd,
	input  wire logic [pss_pkg::ACTION_W-1:0]       action,
	input  wire logic signed [pss_pkg::VALUE_W-1:0] value,
	input  wire logic [pss_pkg::INDEX_W-1:0]        stack_index,
	output logic [pss_pkg::STATUS_W-1:0]            status,
	output logic signed [pss_pkg::VALUE_W-1:0]      top_value,
	output logic                                    top_valid,
	output logic signed [pss_pkg::VALUE_W-1:0]      at_value,
	output logic [pss_pkg::AT_SIZE_W-1:0]           at_size,
	output logic                                    at_valid,
	output logic [pss_pkg::TOTAL_W-1:0]             total_count,
	output logic [pss_pkg::PAGES_W-1:0]             page_count,
	output logic                                    is_empty
);

	localparam int ENTRIES = PAGE_COUNT * PAGE_DEPTH;
	localparam int SW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int FW  = $clog2(PAGE_DEPTH + 1);
	localparam int PW  = $clog2(PAGE_COUNT + 1);
	localparam int TW  = $clog2(ENTRIES + 1);
	localparam int IW  = pss_pkg::INDEX_W;
	localparam int CW  = (PW > IW) ? PW : IW;
	localparam int VW  = pss_pkg::VALUE_W;
	localparam int ASW = pss_pkg::AT_SIZE_W;
	localparam int TOW = pss_pkg::TOTAL_W;
	localparam int PGW = pss_pkg::PAGES_W;

	function automatic logic [AW-1:0] entry_addr(input logic [SW-1:0] s,
		input logic [FW-1:0] f);
		entry_addr = AW'(s) * AW'(PAGE_DEPTH) + AW'(f);
	endfunction

	// captured item
	pss_pkg::action_t act_q;
	logic [VW-1:0]    val_q;
	logic [IW-1:0]    idx_q;

	// page bookkeeping
	logic [SW-1:0] ord_q  [PAGE_COUNT];
	logic [FW-1:0] fill_q [PAGE_COUNT];
	logic [PW-1:0] pu_q;
	logic [TW-1:0] tot_q;

	logic [SW-1:0] ord_n  [PAGE_COUNT];
	logic [FW-1:0] fill_n [PAGE_COUNT];
	logic [PW-1:0] pu_n;
	logic [TW-1:0] tot_n;

	logic [VW-1:0] mem [ENTRIES];

	pss_pkg::status_t st;
	logic             need_new;
	logic             do_pop;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [SW-1:0]    last_slot;
	logic [SW-1:0]    wslot;
	logic [SW-1:0]    lp;
	logic [SW-1:0]    pslot;
	logic             idx_ok;
	logic             top_ok_n;
	logic             at_ok_n;
	logic [SW-1:0]    top_slot;
	logic [SW-1:0]    at_slot;
	logic [AW-1:0]    raddr_top;
	logic [AW-1:0]    raddr_at;

	// result staging
	pss_pkg::status_t st_q;
	logic             top_ok_q;
	logic             at_ok_q;
	logic [FW-1:0]    at_fill_q;
	logic [VW-1:0]    rd_top_q;
	logic [VW-1:0]    rd_at_q;
	logic             byp_top_q;
	logic             byp_at_q;

	// output register
	pss_pkg::status_t out_st_q;
	logic [VW-1:0]    out_top_q;
	logic             out_top_ok_q;
	logic [VW-1:0]    out_at_q;
	logic [ASW-1:0]   out_at_size_q;
	logic             out_at_ok_q;
	logic [TOW-1:0]   out_tot_q;
	logic [PGW-1:0]   out_pu_q;
	logic             out_empty_q;

	always_comb begin
		ord_n     = ord_q;
		fill_n    = fill_q;
		pu_n      = pu_q;
		tot_n     = tot_q;
		st        = pss_pkg::STATUS_OK;
		we        = 1'b0;
		do_pop    = 1'b0;
		lp        = '0;
		pslot     = '0;
		last_slot = ord_q[SW'(pu_q - 1'b1)];
		need_new  = (pu_q == '0) || (fill_q[last_slot] == FW'(PAGE_DEPTH));
		idx_ok    = CW'(idx_q) < CW'(pu_q);
		wslot     = need_new ? ord_q[SW'(pu_q)] : last_slot;
		waddr     = entry_addr(wslot, fill_q[wslot]);
		case (act_q)
			pss_pkg::ACT_PUSH: begin
				if (need_new && (pu_q == PW'(PAGE_COUNT))) begin
					st = pss_pkg::STATUS_FULL;
				end else begin
					we            = cmd.exec;
					fill_n[wslot] = fill_q[wslot] + 1'b1;
					tot_n         = tot_q + 1'b1;
					if (need_new) begin
						pu_n = pu_q + 1'b1;
					end
				end
			end
			pss_pkg::ACT_POP: begin
				if (pu_q == '0) begin
					st = pss_pkg::STATUS_EMPTY;
				end else begin
					do_pop = 1'b1;
					lp     = SW'(pu_q - 1'b1);
				end
			end
			pss_pkg::ACT_POP_AT: begin
				if (!idx_ok) begin
					st = pss_pkg::STATUS_RANGE;
				end else begin
					do_pop = 1'b1;
					lp     = SW'(idx_q);
				end
			end
			pss_pkg::ACT_QUERY: begin
				if (!idx_ok) begin
					st = pss_pkg::STATUS_RANGE;
				end
			end
			default: begin
				st = pss_pkg::STATUS_OK;
			end
		endcase
		if (do_pop) begin
			pslot         = ord_q[lp];
			fill_n[pslot] = fill_q[pslot] - 1'b1;
			tot_n         = tot_q - 1'b1;
			if (fill_q[pslot] == FW'(1)) begin
				// erase the page: later pages close up, freed slot goes to the end
				for (int k = 0; k < PAGE_COUNT; k++) begin
					if ((k >= int'(lp)) && (k + 1 < int'(pu_q))) begin
						ord_n[k] = ord_q[(k + 1) % PAGE_COUNT];
					end
				end
				ord_n[SW'(pu_q - 1'b1)] = pslot;
				pu_n                    = pu_q - 1'b1;
			end
		end

		top_ok_n  = pu_n != '0;
		at_ok_n   = CW'(idx_q) < CW'(pu_n);
		top_slot  = ord_n[SW'(pu_n - 1'b1)];
		at_slot   = ord_n[SW'(idx_q)];
		raddr_top = entry_addr(top_slot, FW'(fill_n[top_slot] - 1'b1));
		raddr_at  = entry_addr(at_slot, FW'(fill_n[at_slot] - 1'b1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PAGE_COUNT; k++) begin
				ord_q[k]  <= SW'(k);
				fill_q[k] <= '0;
			end
			pu_q  <= '0;
			tot_q <= '0;
		end else if (cmd.exec) begin
			ord_q  <= ord_n;
			fill_q <= fill_n;
			pu_q   <= pu_n;
			tot_q  <= tot_n;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= val_q;
		end
		if (cmd.exec) begin
			rd_top_q  <= mem[raddr_top];
			rd_at_q   <= mem[raddr_at];
			byp_top_q <= we && (waddr == raddr_top);
			byp_at_q  <= we && (waddr == raddr_at);
			st_q      <= st;
			top_ok_q  <= top_ok_n;
			at_ok_q   <= at_ok_n;
			at_fill_q <= fill_n[at_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= pss_pkg::action_t'(action);
			val_q <= value;
			idx_q <= stack_index;
		end
		if (cmd.load) begin
			out_st_q      <= st_q;
			out_top_ok_q  <= top_ok_q;
			out_at_ok_q   <= at_ok_q;
			out_top_q     <= !top_ok_q ? '0 : (byp_top_q ? val_q : rd_top_q);
			out_at_q      <= !at_ok_q ? '0 : (byp_at_q ? val_q : rd_at_q);
			out_at_size_q <= at_ok_q ? ASW'(at_fill_q) : '0;
			out_tot_q     <= TOW'(tot_q);
			out_pu_q      <= PGW'(pu_q);
			out_empty_q   <= pu_q == '0;
		end
	end

	assign status      = out_st_q;
	assign top_value   = out_top_q;
	assign top_valid   = out_top_ok_q;
	assign at_value    = out_at_q;
	assign at_size     = out_at_size_q;
	assign at_valid    = out_at_ok_q;
	assign total_count = out_tot_q;
	assign page_count  = out_pu_q;
	assign is_empty    = out_empty_q;

endmodule
`default_nettype wire

// ===== src/paged_stack_set.sv =====
`default_nettype none
// One stack split into PAGE_COUNT pages of PAGE_DEPTH words: push, pop of the last
// page, pop of an indexed page (an emptied page is erased and later pages close up)
// and query, each item answered by one result. Each item passes the EXEC state,
// which updates the page bookkeeping, writes the entry memory and launches both
// top-word reads, and then the DONE state, which collects the registered read data
// into the output register. A new item is taken in DONE as the last result is
// loaded; while the output register is still held by the sink, the block waits.
module paged_stack_set #(
	parameter int PAGE_DEPTH = pss_pkg::PAGE_DEPTH_DEF,
	parameter int PAGE_COUNT = pss_pkg::PAGE_COUNT_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pss_req_if.sink    req,
	pss_rsp_if.source  rsp
);

	pss_pkg::cmd_t cmd;

	pss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	pss_datapath #(
		.PAGE_DEPTH (PAGE_DEPTH),
		.PAGE_COUNT (PAGE_COUNT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.action      (req.action),
		.value       (req.value),
		.stack_index (req.stack_index),
		.status      (rsp.status),
		.top_value   (rsp.top_value),
		.top_valid   (rsp.top_valid),
		.at_value    (rsp.at_value),
		.at_size     (rsp.at_size),
		.at_valid    (rsp.at_valid),
		.total_count (rsp.total_count),
		.page_count  (rsp.page_count),
		.is_empty    (rsp.is_empty)
	);

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
	import pss_pkg::*;

	localparam int DEPTH      = PAGE_DEPTH_DEF;
	localparam int NPAGES     = PAGE_COUNT_DEF;
	localparam int ITEM_GOAL  = 950;
	localparam int HOLD_LEN   = 80;
	localparam int IDLE_LIMIT = 2000;

	typedef enum {STEP_OP, STEP_DRAIN, STEP_HOLD} step_kind_t;

	typedef struct {
		step_kind_t  kind;
		action_t     act;
		logic [31:0] val;
		logic [2:0]  idx;
	} stack_op_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] top_value;
		logic               top_valid;
		logic signed [31:0] at_value;
		logic [4:0]         at_size;
		logic               at_valid;
		logic [7:0]         total_count;
		logic [3:0]         page_count;
		logic               is_empty;
	} stack_result_t;

	logic clk = 1'b0;
	logic arst_n;

	pss_req_if req_bus();
	pss_rsp_if rsp_bus();

	paged_stack_set uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	always #1 clk = ~clk;

	// predicted page set
	logic [31:0] word_mem [NPAGES*DEPTH];
	int unsigned page_fill_m [NPAGES];
	int unsigned page_order [NPAGES];
	int unsigned pages_live;
	int unsigned words_live;

	stack_op_t     pending_ops [$];
	stack_result_t results_due [$];
	int            op_count;
	int            mismatches;
	logic          item_taken;
	int            burst_left;
	int            gap_left;
	int            hold_req;
	int            hold_seen;
	int            hold_left;
	int            phase_left;
	int            stall_pct;
	int            idle_cycles;

	task automatic flag_error(string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %h want %h", name, got, want));
	endtask

	function automatic logic [31:0] top_word(int unsigned slot);
		if (page_fill_m[slot] == 0)
			return '0;
		return word_mem[slot*DEPTH + page_fill_m[slot] - 1];
	endfunction

	// remove top of logical page lp; an emptied page rotates to the end of the order
	function automatic void take_top(int unsigned lp);
		int unsigned slot;
		slot = page_order[lp];
		if (page_fill_m[slot] > 0)
			page_fill_m[slot]--;
		if (words_live > 0)
			words_live--;
		if (page_fill_m[slot] == 0) begin
			for (int unsigned k = lp; k + 1 < pages_live; k++)
				page_order[k] = page_order[k+1];
			page_order[pages_live-1] = slot;
			pages_live--;
		end
	endfunction

	function automatic stack_result_t apply_stack_op(action_t act, logic [31:0] val,
			int unsigned idx);
		stack_result_t r;
		logic fresh;
		int unsigned slot;
		r = '0;
		r.status = STATUS_OK;
		case (act)
			ACT_PUSH: begin
				fresh = (pages_live == 0) || (page_fill_m[page_order[pages_live-1]] >= DEPTH);
				if (fresh && pages_live >= NPAGES) begin
					r.status = STATUS_FULL;
				end else begin
					if (fresh) begin
						page_fill_m[page_order[pages_live]] = 0;
						pages_live++;
					end
					slot = page_order[pages_live-1];
					word_mem[slot*DEPTH + page_fill_m[slot]] = val;
					page_fill_m[slot]++;
					words_live++;
				end
			end
			ACT_POP: begin
				if (pages_live == 0)
					r.status = STATUS_EMPTY;
				else
					take_top(pages_live - 1);
			end
			ACT_POP_AT: begin
				if (idx >= pages_live)
					r.status = STATUS_RANGE;
				else
					take_top(idx);
			end
			default: begin
				if (idx >= pages_live)
					r.status = STATUS_RANGE;
			end
		endcase
		if (pages_live > 0) begin
			r.top_valid = 1'b1;
			r.top_value = top_word(page_order[pages_live-1]);
		end
		if (idx < pages_live) begin
			r.at_valid = 1'b1;
			r.at_value = top_word(page_order[idx]);
			r.at_size  = 5'(page_fill_m[page_order[idx]]);
		end
		r.total_count = 8'(words_live);
		r.page_count  = 4'(pages_live);
		r.is_empty    = (pages_live == 0);
		return r;
	endfunction

	task automatic add_op(action_t a, logic [31:0] v, logic [2:0] i);
		stack_op_t s;
		s.kind = STEP_OP;
		s.act  = a;
		s.val  = v;
		s.idx  = i;
		pending_ops.insert(pending_ops.size(), s);
		op_count++;
	endtask

	task automatic add_step(step_kind_t k);
		stack_op_t s;
		s = '{kind: k, act: ACT_QUERY, val: '0, idx: '0};
		pending_ops.insert(pending_ops.size(), s);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// driver
	always @(negedge clk) begin
		logic offer;
		logic done;
		stack_op_t cur;
		offer = 1'b0;
		done  = 1'b0;
		if (arst_n && (!req_bus.valid || item_taken)) begin
			item_taken = 1'b0;
			while (!done && pending_ops.size() > 0) begin
				case (pending_ops[0].kind)
					STEP_HOLD: begin
						hold_req++;
						void'(pending_ops.pop_front());
					end
					STEP_DRAIN: begin
						if (results_due.size() == 0)
							void'(pending_ops.pop_front());
						else
							done = 1'b1;
					end
					default: done = 1'b1;
				endcase
			end
			if (pending_ops.size() > 0 && pending_ops[0].kind == STEP_OP) begin
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					cur = pending_ops.pop_front();
					offer = 1'b1;
					req_bus.action      <= cur.act;
					req_bus.value       <= cur.val;
					req_bus.stack_index <= cur.idx;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 30);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			req_bus.valid <= offer;
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_bus.ready <= 1'b0;
		end else begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(10, 80);
				case ($urandom_range(0, 4))
					0, 1: stall_pct = 0;
					2: stall_pct = 30;
					3: stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end
			phase_left--;
			rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// monitor: results first, then acceptance of new items
	always @(posedge clk) begin
		stack_result_t got;
		stack_result_t want;
		logic busy;
		if (arst_n) begin
			busy = 1'b0;
			if (rsp_bus.valid && rsp_bus.ready) begin
				busy = 1'b1;
				got.status      = status_t'(rsp_bus.status);
				got.top_value   = rsp_bus.top_value;
				got.top_valid   = rsp_bus.top_valid;
				got.at_value    = rsp_bus.at_value;
				got.at_size     = rsp_bus.at_size;
				got.at_valid    = rsp_bus.at_valid;
				got.total_count = rsp_bus.total_count;
				got.page_count  = rsp_bus.page_count;
				got.is_empty    = rsp_bus.is_empty;
				if (results_due.size() == 0) begin
					flag_error("result with no item outstanding");
				end else begin
					want = results_due.pop_front();
					check_field("status", got.status, want.status);
					check_field("top_value", got.top_value, want.top_value);
					check_field("top_valid", got.top_valid, want.top_valid);
					check_field("at_value", got.at_value, want.at_value);
					check_field("at_size", got.at_size, want.at_size);
					check_field("at_valid", got.at_valid, want.at_valid);
					check_field("total_count", got.total_count, want.total_count);
					check_field("page_count", got.page_count, want.page_count);
					check_field("is_empty", got.is_empty, want.is_empty);
				end
			end
			if (req_bus.valid && req_bus.ready) begin
				busy = 1'b1;
				results_due.insert(results_due.size(), apply_stack_op(
					action_t'(req_bus.action), req_bus.value, req_bus.stack_index));
				item_taken = 1'b1;
			end
			if (busy || (pending_ops.size() == 0 && !req_bus.valid && results_due.size() == 0))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int len;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.action = ACT_PUSH;
		req_bus.value = '0;
		req_bus.stack_index = '0;
		rsp_bus.ready = 1'b0;
		item_taken = 1'b0;
		op_count = 0;
		mismatches = 0;
		burst_left = 0;
		gap_left = 0;
		hold_req = 0;
		hold_seen = 0;
		hold_left = 0;
		phase_left = 0;
		stall_pct = 0;
		idle_cycles = 0;
		pages_live = 0;
		words_live = 0;
		for (int k = 0; k < NPAGES; k++) begin
			page_fill_m[k] = 0;
			page_order[k] = k;
		end

		// empty set, extremes, single page round trip
		add_op(ACT_POP, 32'h0, 3'd0);
		add_op(ACT_POP_AT, 32'h0, 3'd7);
		add_op(ACT_QUERY, 32'h0, 3'd0);
		add_op(ACT_PUSH, 32'h7fff_ffff, 3'd0);
		add_op(ACT_PUSH, 32'h8000_0000, 3'd7);
		add_op(ACT_PUSH, 32'h0, 3'd0);
		add_op(ACT_PUSH, 32'hffff_ffff, 3'd1);
		add_op(ACT_QUERY, 32'h0, 3'd0);
		add_op(ACT_QUERY, 32'h0, 3'd1);
		add_op(ACT_POP_AT, 32'h0, 3'd0);
		add_op(ACT_POP_AT, 32'h0, 3'd1);
		add_op(ACT_POP, 32'h0, 3'd0);
		add_op(ACT_POP, 32'h0, 3'd0);
		add_op(ACT_POP, 32'h0, 3'd0);
		add_op(ACT_POP, 32'h0, 3'd0);
		add_step(STEP_DRAIN);

		// fill every page under a long output stall, overflow, then close up a middle page
		add_step(STEP_HOLD);
		for (int k = 0; k < NPAGES*DEPTH + 2; k++)
			add_op(ACT_PUSH, rand_word(), 3'($urandom_range(0, 7)));
		for (int k = 0; k < NPAGES; k++)
			add_op(ACT_QUERY, 32'h0, 3'(k));
		for (int k = 0; k < DEPTH; k++)
			add_op(ACT_POP_AT, 32'h0, 3'd3);
		add_op(ACT_QUERY, 32'h0, 3'd7);
		add_op(ACT_QUERY, 32'h0, 3'd3);
		add_op(ACT_PUSH, 32'h1234_5678, 3'd7);
		add_step(STEP_DRAIN);

		while (op_count < ITEM_GOAL) begin
			case ($urandom_range(0, 11))
				0, 1, 2, 3: begin
					len = $urandom_range(1, 24);
					repeat (len) add_op(ACT_PUSH, rand_word(), 3'($urandom_range(0, 7)));
				end
				4, 5, 6, 7: begin
					len = $urandom_range(1, 32);
					repeat (len) begin
						case ($urandom_range(0, 3))
							0: add_op(ACT_POP, $urandom, 3'($urandom_range(0, 7)));
							1, 2: add_op(ACT_POP_AT, $urandom, ($urandom_range(0, 3) == 0) ?
								3'($urandom_range(0, 7)) : 3'($urandom_range(0, 2)));
							default: add_op(ACT_QUERY, $urandom, 3'($urandom_range(0, 7)));
						endcase
					end
				end
				8, 9: begin
					len = $urandom_range(1, 10);
					repeat (len) add_op(action_t'($urandom_range(0, 3)), $urandom,
						3'($urandom_range(0, 7)));
				end
				10: add_step(STEP_DRAIN);
				default: add_step(STEP_HOLD);
			endcase
		end

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || req_bus.valid || results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/pss_pkg.sv
src/pss_if.sv
src/pss_ctrl.sv
src/pss_datapath.sv
src/paged_stack_set.sv
tb/tb_top.sv
